/* rtl/uim_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uim_pkg: shared types and constants of the interpolation mask unit
// Pixel and window column types, register map codes and reset values.
// ----------------------------------------------------------------------------
package uim_pkg;

	localparam int PIX_W         = 8;
	localparam int ROW_W         = 16;
	localparam int COL_OUT_W     = 11;
	localparam int WIDTH_REG_W   = 12;
	localparam int APB_DATA_W    = 32;
	localparam int APB_ADDR_W    = 4;
	localparam int MAX_WIDTH_DEF = 2048;
	localparam int MIN_DIM       = 3;
	localparam int NUM_CELLS     = 2;
	localparam int SUM_W         = 10;

	localparam logic                   MASK_MODE_RST    = 1'b1;
	localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RST  = 12'd2048;
	localparam logic [ROW_W-1:0]       IMAGE_HEIGHT_RST = 16'd2048;
	localparam logic                   MODE_NEAREST     = 1'b0;

	typedef logic [PIX_W-1:0] pix_t;

	// One window column, top to bottom.
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	typedef enum logic [1:0] {
		CFG_MASK_MODE    = 2'd0,
		CFG_IMAGE_WIDTH  = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2
	} cfg_idx_t;

endpackage
`default_nettype wire

/* rtl/uim_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uim_if: pixel stream interfaces
// Valid/ready channels for the incoming pixels and the filtered results.
// ----------------------------------------------------------------------------
interface uim_pix_in_if;
	import uim_pkg::*;

	logic valid;
	logic ready;
	pix_t pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface uim_pix_out_if;
	import uim_pkg::*;

	logic                 valid;
	logic                 ready;
	pix_t                 pixel_out;
	logic [ROW_W-1:0]     out_row;
	logic [COL_OUT_W-1:0] out_col;
	logic                 frame_last;

	modport source (output valid, output pixel_out, output out_row, output out_col,
		output frame_last, input ready);
	modport sink (input valid, input pixel_out, input out_row, input out_col,
		input frame_last, output ready);
endinterface
`default_nettype wire

/* rtl/uim_col_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uim_col_cell: one window column cell
// Holds one three-pixel column and hands it on to the next cell on each shift.
// ----------------------------------------------------------------------------
module uim_col_cell
	import uim_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire col_t d,
	output col_t      q
);

	col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (en) begin
			col_q <= d;
		end
	end

	assign q = col_q;

endmodule
`default_nettype wire

/* rtl/uim_line_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uim_line_store: dual line store
// One memory word per column holds the upper and the lower stored row. After
// reset a clearing pass writes zeros to every word, one word per cycle.
// ----------------------------------------------------------------------------
module uim_line_store
	import uim_pkg::*;
#(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output col_t               rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire pix_t          wr_upper,
	input  wire pix_t          wr_lower,
	output logic               busy
);

	logic [2*PIX_W-1:0] mem_q [DEPTH];
	logic [2*PIX_W-1:0] rd_q;
	logic [AW-1:0]      clr_addr_q;
	logic               clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem_q[wr_addr] <= {wr_upper, wr_lower};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// The bottom pixel of the column comes from the stream, not the store.
	assign rd_data = '{top: rd_q[2*PIX_W-1:PIX_W], mid: rd_q[PIX_W-1:0], bot: '0};
	assign busy    = clr_busy_q;

endmodule
`default_nettype wire

/* rtl/upsample_interp_mask_3x3_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// upsample_interp_mask_3x3_unit: 3x3 interpolation mask over an upsampled image
// Line stores, a chain of window column cells and a fixed mask per pixel.
// ----------------------------------------------------------------------------
// Pixels of a zero-interleaved, 2x-upsampled grey image arrive in raster order,
// one request per clock at most, and the unit sustains one pixel per clock unless
// the output stalls. A pixel is accepted and its line store column is read at the
// same edge. In the next cycle that column completes the window and the mask is
// evaluated; the result is registered as stage one moves on. The figure of one pixel per
// clock is set by the single line store memory, which takes one read and one
// write per pixel at different columns. When the pixel at row r, column c
// arrives with r and c both at least one, the result centred at (r-1, c-1) is
// produced, so rows 0 to H-2 and columns 0 to W-2 come out; output row 0 and
// column 0 carry zero, and frame_last marks result (H-2, W-2). Mask mode 0 sums
// the centre with its upper, left and upper-left neighbours; mode 1 is the
// bilinear mask of quarter corners, half edges and the full centre, each term
// truncated. Sums saturate at 255. The image width is clamped to 3..MAX_WIDTH
// and the height is raised to at least 3. After reset the line store is
// cleared, during which no pixel is accepted; register writes are taken as usual.
// The user must write registers only while the unit is idle; the unit does not enforce it.
// ----------------------------------------------------------------------------
module upsample_interp_mask_3x3_unit
	import uim_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	uim_pix_in_if.sink                 pix_in,
	uim_pix_out_if.source              pix_out,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;

	// Configuration registers.
	logic                   mask_mode_q;
	logic [WIDTH_REG_W-1:0] image_width_q;
	logic [ROW_W-1:0]       image_height_q;

	// Input side position counters.
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_q;

	// Stage one: accepted pixel waiting for its line store column.
	logic             valid_s1;
	pix_t             pix_s1;
	logic [ROW_W-1:0] row_s1;
	logic [CW-1:0]    col_s1;

	// Output register.
	logic                 valid_s2;
	pix_t                 pixel_s2;
	logic [ROW_W-1:0]     row_s2;
	logic [COL_OUT_W-1:0] col_s2;
	logic                 last_s2;

	logic          cfg_wr;
	cfg_idx_t      cfg_idx;
	logic [WW-1:0] width_ext;
	logic [CW:0]   eff_w;
	logic [ROW_W-1:0] eff_h;
	logic          in_fire;
	logic          emit_s1;
	logic          out_free;
	logic          adv_s1;
	logic          ls_busy;
	col_t          ls_col;
	col_t          cell_in  [NUM_CELLS];
	col_t          cell_out [NUM_CELLS];
	logic [SUM_W-1:0] sum;
	pix_t          pixel_res;
	logic          last_res;
	logic [CW-1:0] ocol;

	// ------------------------------------------------------------------
	// Register port. Register i sits at byte address 4*i.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = cfg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_mode_q    <= MASK_MODE_RST;
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				CFG_MASK_MODE:    mask_mode_q    <= pwdata[0];
				CFG_IMAGE_WIDTH:  image_width_q  <= pwdata[WIDTH_REG_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			CFG_MASK_MODE:    prdata = APB_DATA_W'(mask_mode_q);
			CFG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_q);
			CFG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_q);
			default:          prdata = '0;
		endcase
	end

	// Effective frame size: width clamped to the store depth, height at least 3.
	always_comb begin
		width_ext = WW'(image_width_q);
		if (width_ext < WW'(MIN_DIM)) begin
			eff_w = (CW + 1)'(MIN_DIM);
		end else if (width_ext > WW'(MAX_WIDTH)) begin
			eff_w = (CW + 1)'(MAX_WIDTH);
		end else begin
			eff_w = (CW + 1)'(width_ext);
		end
		eff_h = (image_height_q < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : image_height_q;
	end

	// ------------------------------------------------------------------
	// Handshake. Stage one moves on when its result, if any, has room in the
	// output register; pixels that give no result move on at once.
	// ------------------------------------------------------------------
	assign emit_s1      = valid_s1 && (row_s1 != '0) && (col_s1 != '0);
	assign out_free     = !valid_s2 || pix_out.ready;
	assign adv_s1       = valid_s1 && (!emit_s1 || out_free);
	assign pix_in.ready = !ls_busy && (!valid_s1 || adv_s1);
	assign in_fire      = pix_in.valid && pix_in.ready;

	// Position counters; a counter beyond a newly reduced bound wraps on advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_fire) begin
			if ((CW + 1)'(col_q) + 1'b1 >= eff_w) begin
				col_q <= '0;
				if ((ROW_W + 1)'(row_q) + 1'b1 >= (ROW_W + 1)'(eff_h)) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1 <= pix_in.pixel_in;
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
	end

	// ------------------------------------------------------------------
	// Line store: read at acceptance, written back when stage one moves on.
	// The upper row takes the old lower row, the lower row takes the pixel.
	// ------------------------------------------------------------------
	uim_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_fire),
		.rd_addr  (col_q),
		.rd_data  (ls_col),
		.wr_en    (adv_s1),
		.wr_addr  (col_s1),
		.wr_upper (ls_col.mid),
		.wr_lower (pix_s1),
		.busy     (ls_busy)
	);

	// ------------------------------------------------------------------
	// Window: the newest column feeds a chain of cells, each one column older.
	// ------------------------------------------------------------------
	assign cell_in[0] = '{top: ls_col.top, mid: ls_col.mid, bot: pix_s1};

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cells
		if (i > 0) begin : g_link
			assign cell_in[i] = cell_out[i-1];
		end
		uim_col_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv_s1),
			.d      (cell_in[i]),
			.q      (cell_out[i])
		);
	end

	// ------------------------------------------------------------------
	// Mask. Column 0 of the window is cell_in[0], columns 1 and 2 the cells.
	// ------------------------------------------------------------------
	always_comb begin
		if (mask_mode_q == MODE_NEAREST) begin
			sum = SUM_W'(cell_out[1].top) + SUM_W'(cell_out[0].top)
				+ SUM_W'(cell_out[1].mid) + SUM_W'(cell_out[0].mid);
		end else begin
			sum = SUM_W'(cell_out[1].top >> 2) + SUM_W'(cell_in[0].top >> 2)
				+ SUM_W'(cell_out[1].bot >> 2) + SUM_W'(cell_in[0].bot >> 2)
				+ SUM_W'(cell_out[0].top >> 1) + SUM_W'(cell_out[1].mid >> 1)
				+ SUM_W'(cell_in[0].mid >> 1) + SUM_W'(cell_out[0].bot >> 1)
				+ SUM_W'(cell_out[0].mid);
		end
		ocol = col_s1 - 1'b1;
		// The top output row and the left output column are forced to zero.
		if (row_s1 == ROW_W'(1) || ocol == '0) begin
			pixel_res = '0;
		end else if (sum > SUM_W'({PIX_W{1'b1}})) begin
			pixel_res = '1;
		end else begin
			pixel_res = PIX_W'(sum);
		end
		last_res = (row_s1 == eff_h - 1'b1) && ((CW + 1)'(col_s1) == eff_w - 1'b1);
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			valid_s2 <= 1'b1;
		end else if (pix_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			pixel_s2 <= pixel_res;
			row_s2   <= row_s1 - 1'b1;
			col_s2   <= COL_OUT_W'(ocol);
			last_s2  <= last_res;
		end
	end

	assign pix_out.valid      = valid_s2;
	assign pix_out.pixel_out  = pixel_s2;
	assign pix_out.out_row    = row_s2;
	assign pix_out.out_col    = col_s2;
	assign pix_out.frame_last = last_s2;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// The line store is never read and written at the same column in a cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && adv_s1) |-> (col_q != col_s1))
		else $error("line store read and write hit the same column");

	// Border results carry zero.
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (row_s2 == '0 || col_s2 == '0)) |-> (pixel_s2 == '0))
		else $error("border result is not zero");

	// The last result of a frame sits in the last emitted column and row.
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2) |->
		(col_s2 == COL_OUT_W'(eff_w - 2'd2) && row_s2 == eff_h - 2'd2))
		else $error("frame_last at a wrong position");

	// No pixel is taken while the line store clearing pass runs.
	a_clear_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ls_busy |=> !valid_s1 || $past(!in_fire))
		else $error("pixel accepted during the clearing pass");

endmodule
`default_nettype wire

/* tb/upsample_interp_mask_3x3_check.sv */
// ----------------------------------------------------------------------------
// upsample_interp_mask_3x3_check: result checker for the interpolation mask unit
// Watches the pixel channels and the register port, keeps its own copy of the
// line stores, window and counters, and compares every filtered pixel in order.
// ----------------------------------------------------------------------------
module upsample_interp_mask_3x3_check
	import uim_pkg::*;
#(
	parameter int MAX_W = MAX_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	uim_pix_in_if                      pix_in,
	uim_pix_out_if                     pix_out,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic                  pready,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output int                         errors,
	output int                         outstanding,
	output int                         checked
);

	typedef struct packed {
		pix_t                 pixel;
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
		logic                 last;
	} filtered_t;

	logic                   mode;
	logic [WIDTH_REG_W-1:0] width_reg;
	logic [ROW_W-1:0]       height_reg;
	pix_t                   row_two_up [MAX_W];
	pix_t                   row_one_up [MAX_W];
	col_t                   near_col;
	col_t                   far_col;
	int unsigned            next_row;
	int unsigned            next_col;
	filtered_t              filtered_q [$];
	filtered_t              want;
	int                     err_count;
	int                     seen_count;

	// Builds the window for one incoming pixel, queues the filtered pixel it
	// completes (if any) and advances the line stores and the position.
	task automatic interpolate_pixel(input pix_t px);
		int unsigned wd;
		int unsigned ht;
		int unsigned r;
		int unsigned c;
		int unsigned sum;
		col_t        cur;
		filtered_t   res;
		wd = (width_reg < MIN_DIM) ? MIN_DIM : ((width_reg > MAX_W) ? MAX_W : width_reg);
		ht = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
		r = next_row;
		c = next_col;
		cur.top = row_two_up[c];
		cur.mid = row_one_up[c];
		cur.bot = px;
		if (r >= 1 && c >= 1) begin
			sum = 0;
			if (r != 1 && c != 1) begin
				if (mode == MODE_NEAREST) begin
					sum = far_col.top + near_col.top + far_col.mid + near_col.mid;
				end else begin
					sum = (far_col.top >> 2) + (cur.top >> 2) + (far_col.bot >> 2)
						+ (cur.bot >> 2) + (near_col.top >> 1) + (far_col.mid >> 1)
						+ (cur.mid >> 1) + (near_col.bot >> 1) + near_col.mid;
				end
				if (sum > 255) sum = 255;
			end
			res.pixel = pix_t'(sum);
			res.row   = ROW_W'(r - 1);
			res.col   = COL_OUT_W'(c - 1);
			res.last  = (r == ht - 1) && (c == wd - 1);
			filtered_q.push_back(res);
		end
		far_col       = near_col;
		near_col      = cur;
		row_two_up[c] = cur.mid;
		row_one_up[c] = px;
		if (c + 1 >= wd) begin
			next_col = 0;
			next_row = (r + 1 >= ht) ? 0 : r + 1;
		end else begin
			next_col = c + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode       = MASK_MODE_RST;
			width_reg  = IMAGE_WIDTH_RST;
			height_reg = IMAGE_HEIGHT_RST;
			foreach (row_two_up[i]) begin
				row_two_up[i] = '0;
				row_one_up[i] = '0;
			end
			near_col = '0;
			far_col  = '0;
			next_row = 0;
			next_col = 0;
			filtered_q.delete();
		end else begin
			if (pix_in.valid && pix_in.ready) interpolate_pixel(pix_in.pixel_in);
			if (pix_out.valid && pix_out.ready) begin
				seen_count++;
				if (filtered_q.size() == 0) begin
					$error("unexpected filtered pixel at row %0d, column %0d",
						pix_out.out_row, pix_out.out_col);
					err_count++;
				end else begin
					want = filtered_q.pop_front();
					if (pix_out.pixel_out !== want.pixel) begin
						$error("pixel_out: expected %0d, actual %0d", want.pixel,
							pix_out.pixel_out);
						err_count++;
					end
					if (pix_out.out_row !== want.row) begin
						$error("out_row: expected %0d, actual %0d", want.row, pix_out.out_row);
						err_count++;
					end
					if (pix_out.out_col !== want.col) begin
						$error("out_col: expected %0d, actual %0d", want.col, pix_out.out_col);
						err_count++;
					end
					if (pix_out.frame_last !== want.last) begin
						$error("frame_last: expected %0d, actual %0d", want.last,
							pix_out.frame_last);
						err_count++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (cfg_idx_t'(paddr[3:2]))
					CFG_MASK_MODE:    mode       = pwdata[0];
					CFG_IMAGE_WIDTH:  width_reg  = pwdata[WIDTH_REG_W-1:0];
					CFG_IMAGE_HEIGHT: height_reg = pwdata[ROW_W-1:0];
					default: ;
				endcase
			end
		end
		errors      <= err_count;
		outstanding <= filtered_q.size();
		checked     <= seen_count;
	end

endmodule

/* tb/upsample_interp_mask_3x3_unit_test.sv */
// ----------------------------------------------------------------------------
// upsample_interp_mask_3x3_unit_test: testbench of the interpolation mask unit
// Drives pixel requests and register writes, applies back-pressure and leaves
// the prediction and comparison to the checker instantiated beside the unit.
// ----------------------------------------------------------------------------
module upsample_interp_mask_3x3_unit_test;
	import uim_pkg::*;

	localparam int CLK_PERIOD   = 20;
	// Cycles let pass after the last result before a register write or the verdict.
	localparam int DRAIN_CYCLES = 8;
	// Length of the deliberate output stall, long enough to fill the unit.
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_ITEMS = 800;
	// Width of the wide phase; two full rows and a few pixels of the third
	// are fed, so that the line stores are written and read over many columns.
	localparam int WIDE_W       = 400;
	localparam int WIDE_ITEMS   = 2 * WIDE_W + 4;
	localparam int LIMIT_CYCLES = 600000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int errors;
	int outstanding;
	int checked;

	// Set for a phase in which neither side idles.
	bit          calm;
	// Asks the receiving side for one long stall.
	bit          long_hold_req;
	int unsigned sent;
	int unsigned phases;

	uim_pix_in_if  pin ();
	uim_pix_out_if pout ();

	upsample_interp_mask_3x3_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pin),
		.pix_out (pout),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	upsample_interp_mask_3x3_check check (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_in      (pin),
		.pix_out     (pout),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// A hung handshake or a result that never comes ends the run here.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("DONE: errors detected");
		$finish;
	end

	// Register write over the configuration port: a setup cycle, then an
	// access cycle that completes at the first edge with pready high, then
	// a return to idle before the next transfer.
	task automatic cfg_write(input cfg_idx_t idx, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one pixel request after a random gap and returns at the edge at
	// which the unit takes it. Valid is left high, so that back-to-back
	// requests need no extra assignment; the next call or the drain lowers it.
	task automatic offer_pixel(input pix_t value);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			pin.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pin.valid    <= 1'b1;
		pin.pixel_in <= value;
		@(posedge clk);
		while (!pin.ready) @(posedge clk);
		sent++;
	endtask

	// Random pixel content, leaning a little towards black and full white so
	// that saturation and all-zero windows come up often.
	task automatic offer_random_pixels(input int unsigned count);
		pix_t value;
		repeat (count) begin
			case ($urandom_range(0, 7))
				0: value = '0;
				1: value = '1;
				default: value = pix_t'($urandom_range(0, 255));
			endcase
			offer_pixel(value);
		end
	endtask

	// The sender stops and waits until every predicted result has been
	// taken, then waits DRAIN_CYCLES more for the pipeline to empty, since a
	// border pixel may still be in flight without a result of its own.
	task automatic wait_drained();
		pin.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		phases++;
	endtask

	// Receiving side: before every result it may idle, unless the
	// phase is calm. When asked, it holds ready low for a long stretch, which
	// it counts itself, while the sender keeps offering requests.
	initial begin
		int unsigned hold;
		pout.ready = 1'b0;
		forever begin
			if (long_hold_req) begin
				pout.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end else begin
				hold = calm ? 0 : $urandom_range(0, 3);
				if (hold != 0) begin
					pout.ready <= 1'b0;
					repeat (hold) @(posedge clk);
				end
			end
			pout.ready <= 1'b1;
			@(posedge clk);
			while (!(pout.valid && pout.ready)) @(posedge clk);
		end
	end

	initial begin
		int unsigned rand_items;
		int unsigned count;
		int unsigned w;
		int unsigned h;
		int unsigned ew;
		int unsigned eh;

		// Every input is known from the first instant; reset is asserted at time
		// zero and released once, at a clock edge.
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		pin.valid    = 1'b0;
		pin.pixel_in = '0;
		calm         = 1'b0;
		rand_items   = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The unit clears its line store after reset and takes
		// no request meanwhile, but register writes go through, so the first
		// setting is made straight away.
		// A 3x3 frame of full white with the nearest-neighbour mask: the
		// border results come out as zero and the single inner one saturates.
		cfg_write(CFG_MASK_MODE, APB_DATA_W'(MODE_NEAREST));
		cfg_write(CFG_IMAGE_WIDTH, 3);
		cfg_write(CFG_IMAGE_HEIGHT, 3);
		repeat (9) offer_pixel('1);
		wait_drained();
		// The same frame with the bilinear mask, which also saturates.
		cfg_write(CFG_MASK_MODE, APB_DATA_W'(!MODE_NEAREST));
		repeat (9) offer_pixel('1);
		wait_drained();
		// A width of zero is clamped and a height of one is raised, both to
		// the minimum of three; a checkerboard of black and white is fed.
		cfg_write(CFG_IMAGE_WIDTH, 0);
		cfg_write(CFG_IMAGE_HEIGHT, 1);
		for (int i = 0; i < 9; i++) offer_pixel(i[0] ? '0 : '1);
		wait_drained();

		// Wide phase with the height at its largest. The receiver stalls for
		// a long time after its first result, so that the output fills and the
		// input is held off.
		cfg_write(CFG_IMAGE_WIDTH, WIDE_W);
		cfg_write(CFG_IMAGE_HEIGHT, 32'h0000_FFFF);
		long_hold_req = 1'b1;
		offer_random_pixels(WIDE_ITEMS);
		wait_drained();

		// Random part: each phase writes a new size, now and then a new mask,
		// and then mostly feeds whole frames. Phases with a height above 16 and a
		// quarter of the rest feed a broken run that may leave the frame unfinished,
		// so the next size is applied with the counters somewhere in the middle.
		while (rand_items < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1) == 1) cfg_write(CFG_MASK_MODE, $urandom_range(0, 1));
			case ($urandom_range(0, 7))
				0: w = $urandom_range(0, 2);
				1: w = $urandom_range(13, 40);
				default: w = $urandom_range(3, 12);
			endcase
			case ($urandom_range(0, 11))
				0: h = $urandom_range(0, 2);
				1: h = 65535;
				default: h = $urandom_range(3, 8);
			endcase
			cfg_write(CFG_IMAGE_WIDTH, w);
			cfg_write(CFG_IMAGE_HEIGHT, h);
			ew = (w < MIN_DIM) ? MIN_DIM : w;
			eh = (h < MIN_DIM) ? MIN_DIM : h;
			if (eh > 16 || $urandom_range(0, 3) == 0) begin
				count = $urandom_range(1, 4 * ew);
			end else begin
				count = ew * eh * $urandom_range(1, 2);
			end
			offer_random_pixels(count);
			rand_items += count;
			wait_drained();
		end
		calm = 1'b0;

		$display("Run covered %0d pixel requests in %0d phases; %0d filtered results checked.",
			sent, phases, checked);
		$display("Both masks, widths from 3 to %0d and heights from 3 to 65535 were used.",
			WIDE_W);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
